[hdl/assert_macros.svh]
// Assertion macros for the RTL; the top-level receiver file includes them.
// Synthesis builds define SYNTHESIS, which turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge while reset is released.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
// Condition that must never be true while reset is released.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

[hdl/stxr_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stxr_pkg
// Types, constants and helper functions of the STX/ETX frame receiver.
// -----------------------------------------------------------------------------
package stxr_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    // Control characters.
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ENQ = 8'h05;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_RS  = 8'h1E;
    localparam logic [7:0] CH_US  = 8'h1F;
    localparam logic [7:0] CH_SPC = 8'h20;
    localparam logic [7:0] CH_TIL = 8'h7E;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REPLY   = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_REJECT  = 3'd0;
    localparam logic [2:0] ST_STORED  = 3'd1;
    localparam logic [2:0] ST_FRAME   = 3'd2;
    localparam logic [2:0] ST_START   = 3'd3;
    localparam logic [2:0] ST_ENQ_ACK = 3'd4;
    localparam logic [2:0] ST_NONE    = 3'd0;

    // Configuration register indexes.
    localparam logic CFG_COMMAND = 1'b0;
    localparam logic CFG_LOG     = 1'b1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [PTR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] fill;
    } ctl_status_t;

    function automatic logic storable(input logic [7:0] b,
                                      input logic [7:0] cmd,
                                      input logic [7:0] lg);
        logic printable;
        logic ctrl_char;
        printable = (b >= CH_SPC) && (b <= CH_TIL);
        ctrl_char = (b == CH_LF) || (b == CH_STX) || (b == CH_ETX) ||
                    (b == CH_ENQ) || (b == CH_ACK) || (b == CH_NAK) ||
                    (b == CH_RS) || (b == CH_US) || (b == cmd) || (b == lg);
        return printable || ctrl_char;
    endfunction

endpackage

[hdl/stx_etx_frame_receiver.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stx_etx_frame_receiver
// Byte-stream receiver for STX/ETX framed messages with enquiry replies.
// -----------------------------------------------------------------------------
// Each received byte yields one or more result items; the final item of a
// byte carries tlast and the status. Most bytes give a single status item and
// are taken at one per cycle while the output register can move. An ETX that
// closes a frame of N stored bytes streams those bytes from the 64-entry
// buffer memory (a first read, then one byte a cycle through the memory
// read port while the output register can move), and an enquiry reply
// sends STX, ACK and ETX; no new byte is taken until that run has been
// handed to the output register. The buffer memory needs no clearing after
// reset: only entries below the fill count are ever read.
`include "assert_macros.svh"

module stx_etx_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: index 0 is command_code, index 1 is log_code.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data, [10:8] status, [15:11] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last
);
    import stxr_pkg::*;

    logic        slot_free;
    logic        res_valid;
    result_t     res;
    mem_req_t    mem_req;
    logic [7:0]  rd_data;
    ctl_status_t stat;

    logic        out_valid_reg;
    result_t     out_reg;

    // The output register frees up when it is empty or being taken this cycle.
    assign slot_free = !out_valid_reg || m_tready;

    stxr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_ready  (s_tready),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .stat      (stat)
    );

    stxr_buf u_buf (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg <= res_valid;
        end
    end

    // Payload register, loaded whenever the sequencer hands over an item.
    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.status, out_reg.data};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

    // No byte is taken while a frame or reply run is in progress.
    `ASSERT_NEVER(a_no_accept_busy, clk, rst_n, stat.busy && s_tready)
    // The fill count never passes the buffer depth.
    `ASSERT_NEVER(a_fill_bound, clk, rst_n, stat.fill > CNT_W'(BUFFER_DEPTH))
    // Status-only items carry zero data.
    `ASSERT_CLK(a_status_zero, clk, rst_n,
        (m_tvalid && (m_tuser == KIND_STATUS)) |-> (m_tdata[7:0] == 8'd0))
    // Status is only given on the last item of a run.
    `ASSERT_CLK(a_status_last, clk, rst_n,
        (m_tvalid && !m_tlast) |-> (m_tdata[10:8] == ST_NONE))

endmodule

[hdl/stxr_buf.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stxr_buf
// Frame buffer: one write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module stxr_buf (
    input  logic             clk,
    input  stxr_pkg::mem_req_t req,
    output logic [7:0]       rd_data
);
    import stxr_pkg::*;

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/stxr_ctrl.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// stxr_ctrl
// Sequencer: classifies each byte, updates the buffer state and walks the
// buffer or the reply sequence when a frame closes.
// -----------------------------------------------------------------------------
module stxr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_data,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    output logic                  in_ready,
    input  logic                  slot_free,
    output logic                  res_valid,
    output stxr_pkg::result_t     res,
    output stxr_pkg::mem_req_t    mem_req,
    input  logic [7:0]            rd_data,
    output stxr_pkg::ctl_status_t stat
);
    import stxr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_REPLY = 2'd1;
    localparam logic [1:0] S_DUMP  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             open_reg, open_next;
    logic             first_enq_reg, first_enq_next;
    logic             step_reg, step_next;
    logic [PTR_W-1:0] idx_reg, idx_next;
    logic [7:0]       cmd_reg, log_reg;

    logic accept;
    logic dump_fin;

    assign in_ready = (state_reg == S_IDLE) && slot_free;
    assign accept   = in_valid && in_ready;
    assign dump_fin = ({1'b0, idx_reg} == (fill_reg - CNT_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg <= 8'd1;
            log_reg <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COMMAND: cmd_reg <= cfg_data;
                CFG_LOG:     log_reg <= cfg_data;
                default:     cmd_reg <= cmd_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        open_next      = open_reg;
        first_enq_next = first_enq_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        res_valid      = 1'b0;
        res            = '{kind: KIND_STATUS, data: 8'd0, status: ST_NONE, last: 1'b1};
        mem_req        = '{we: 1'b0, waddr: fill_reg[PTR_W-1:0], wdata: in_byte,
                           re: 1'b0, raddr: idx_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_valid = 1'b1;
                    if (in_byte == CH_STX)
                    begin
                        res.status = ST_START;
                        if (open_reg)
                        begin
                            fill_next = '0;
                            open_next = 1'b0;
                        end
                        else
                        begin
                            open_next = 1'b1;
                        end
                    end
                    else if ((in_byte == CH_ETX) && open_reg)
                    begin
                        if ((fill_reg != '0) && first_enq_reg)
                        begin
                            res        = '{kind: KIND_REPLY, data: CH_STX,
                                           status: ST_NONE, last: 1'b0};
                            step_next  = 1'b0;
                            state_next = S_REPLY;
                        end
                        else if (fill_reg == '0)
                        begin
                            res.status = ST_FRAME;
                            open_next  = 1'b0;
                        end
                        else
                        begin
                            // Nothing to emit yet; fetch the first stored byte.
                            res_valid   = 1'b0;
                            mem_req.re  = 1'b1;
                            mem_req.raddr = '0;
                            idx_next    = '0;
                            state_next  = S_DUMP;
                        end
                    end
                    else if (storable(in_byte, cmd_reg, log_reg) &&
                             (fill_reg < CNT_W'(BUFFER_DEPTH)))
                    begin
                        mem_req.we = 1'b1;
                        fill_next  = fill_reg + CNT_W'(1);
                        if (fill_reg == '0)
                        begin
                            first_enq_next = (in_byte == CH_ENQ);
                        end
                        res.status = ST_STORED;
                    end
                    else
                    begin
                        res.status = ST_REJECT;
                    end
                end
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    res_valid = 1'b1;
                    if (!step_reg)
                    begin
                        res       = '{kind: KIND_REPLY, data: CH_ACK,
                                      status: ST_NONE, last: 1'b0};
                        step_next = 1'b1;
                    end
                    else
                    begin
                        res        = '{kind: KIND_REPLY, data: CH_ETX,
                                       status: ST_ENQ_ACK, last: 1'b1};
                        state_next = S_IDLE;
                    end
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    res_valid = 1'b1;
                    res       = '{kind: KIND_PAYLOAD, data: rd_data,
                                  status: dump_fin ? ST_FRAME : ST_NONE, last: dump_fin};
                    if (dump_fin)
                    begin
                        fill_next  = '0;
                        open_next  = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // Fetch the next byte while this one goes out.
                        idx_next      = idx_reg + PTR_W'(1);
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg + PTR_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            open_reg      <= 1'b0;
            first_enq_reg <= 1'b0;
            step_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            open_reg      <= open_next;
            first_enq_reg <= first_enq_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
        end
    end

    assign stat = '{busy: (state_reg != S_IDLE), fill: fill_reg};

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the STX/ETX frame receiver.
// A table of directed bytes runs first, followed by random framed traffic
// under several command/log register settings. Every result item is compared
// with an expected item from the table or from a bench-side model of the
// receiver's buffer and frame state. Both stream sides idle at random, and the
// output side once stalls long enough to back the block up onto its input.
// -----------------------------------------------------------------------------
module tb;
    import stxr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 5000;
    localparam int HOLD_AT     = 50;
    localparam int HOLD_CYCLES = 300;
    localparam int N_DIRECTED  = 25;
    localparam int ROW_W       = $clog2(N_DIRECTED);

    // One directed row: the byte to send and, where the outcome is a single
    // status item that is obvious from the byte alone, that status.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed_exp;
        logic [2:0] st;
    } stim_row_t;

    // Registers hold their reset values (command 0x01, log 0x04) here.
    stim_row_t dir_rows [N_DIRECTED] = '{
        '{8'h00,  1'b1, ST_REJECT},
        '{8'hFF,  1'b1, ST_REJECT},
        '{8'h7F,  1'b1, ST_REJECT},   // just above the printable range
        '{8'h80,  1'b1, ST_REJECT},
        '{CH_US,  1'b1, ST_STORED},   // stored while no frame is open
        '{CH_SPC, 1'b1, ST_STORED},
        '{CH_TIL, 1'b1, ST_STORED},
        '{CH_LF,  1'b1, ST_STORED},
        '{8'h01,  1'b1, ST_STORED},   // command code at its reset value
        '{8'h04,  1'b1, ST_STORED},   // log code at its reset value
        '{CH_ETX, 1'b1, ST_STORED},   // ETX outside a frame is plain data
        '{CH_STX, 1'b1, ST_START},    // opens and keeps what is buffered
        '{CH_NAK, 1'b1, ST_STORED},
        '{CH_ETX, 1'b0, ST_NONE},     // delivers all eight buffered bytes
        '{CH_STX, 1'b1, ST_START},
        '{CH_ETX, 1'b1, ST_FRAME},    // empty frame: one status item
        '{CH_STX, 1'b1, ST_START},
        '{CH_ENQ, 1'b1, ST_STORED},
        '{8'h41,  1'b1, ST_STORED},
        '{CH_ETX, 1'b0, ST_NONE},     // enquiry reply, buffer kept
        '{CH_ETX, 1'b0, ST_NONE},     // same reply again
        '{CH_STX, 1'b1, ST_START},    // restart while open clears the buffer
        '{CH_RS,  1'b1, ST_STORED},
        '{CH_ACK, 1'b1, ST_STORED},
        '{8'h1D,  1'b1, ST_REJECT}    // just below RS
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [7:0] data, [10:8] status, [15:11] zero
    logic [1:0]  m_tuser;    // [1:0] kind
    logic        m_tlast;

    // Bench copy of the receiver state and its two registers.
    logic [7:0] model_buf [BUFFER_DEPTH];
    int         model_fill;
    bit         model_open;
    logic [7:0] model_cmd;
    logic [7:0] model_log;

    result_t step_out[$];          // results of the byte just accepted
    result_t pending_results[$];   // results still owed by the block

    int items_sent;
    int results_seen;
    int error_count;
    int cycle_count;
    bit idle_on;

    stx_etx_frame_receiver u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // A hung block shows up here rather than as a silent hang.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic result_t make_result(input logic [1:0] kind,
                                            input logic [7:0] data,
                                            input logic [2:0] status,
                                            input logic       last);
        result_t r;
        r.kind   = kind;
        r.data   = data;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    function automatic bit is_storable(input logic [7:0] b);
        if (b >= CH_SPC && b <= CH_TIL)
            return 1'b1;
        return b == CH_LF || b == CH_STX || b == CH_ETX || b == CH_ENQ ||
               b == CH_ACK || b == CH_NAK || b == CH_RS || b == CH_US ||
               b == model_cmd || b == model_log;
    endfunction

    // Advances the bench state by one received byte and leaves the results
    // that byte causes in step_out.
    function automatic void predict_rx_byte(input logic [7:0] b);
        step_out.delete();
        if (b == CH_STX)
        begin
            // A second STX abandons the open frame; a first one opens it.
            if (model_open)
            begin
                model_fill = 0;
                model_open = 1'b0;
            end
            else
                model_open = 1'b1;
            step_out.push_back(make_result(KIND_STATUS, 8'h00, ST_START, 1'b1));
        end
        else if (b == CH_ETX && model_open)
        begin
            if (model_fill > 0 && model_buf[0] == CH_ENQ)
            begin
                // Enquiry: answer with STX ACK ETX and leave the frame alone.
                step_out.push_back(make_result(KIND_REPLY, CH_STX, ST_NONE, 1'b0));
                step_out.push_back(make_result(KIND_REPLY, CH_ACK, ST_NONE, 1'b0));
                step_out.push_back(make_result(KIND_REPLY, CH_ETX, ST_ENQ_ACK, 1'b1));
            end
            else
            begin
                if (model_fill == 0)
                    step_out.push_back(make_result(KIND_STATUS, 8'h00, ST_FRAME, 1'b1));
                else
                    for (int i = 0; i < model_fill; i++)
                    begin
                        if (i == model_fill - 1)
                            step_out.push_back(make_result(KIND_PAYLOAD,
                                                           model_buf[PTR_W'(i)],
                                                           ST_FRAME, 1'b1));
                        else
                            step_out.push_back(make_result(KIND_PAYLOAD,
                                                           model_buf[PTR_W'(i)],
                                                           ST_NONE, 1'b0));
                    end
                model_fill = 0;
                model_open = 1'b0;
            end
        end
        else if (!is_storable(b) || model_fill >= BUFFER_DEPTH)
            step_out.push_back(make_result(KIND_STATUS, 8'h00, ST_REJECT, 1'b1));
        else
        begin
            model_buf[PTR_W'(model_fill)] = b;
            model_fill++;
            step_out.push_back(make_result(KIND_STATUS, 8'h00, ST_STORED, 1'b1));
        end
    endfunction

    // A storable byte that neither closes nor restarts an open frame.
    function automatic logic [7:0] pick_payload();
        logic [7:0] b;
        if ($urandom_range(0, 3) != 0)
            b = 8'($urandom_range(CH_SPC, CH_TIL));
        else
            case ($urandom_range(0, 7))
                0:       b = CH_LF;
                1:       b = CH_ENQ;
                2:       b = CH_ACK;
                3:       b = CH_NAK;
                4:       b = CH_RS;
                5:       b = CH_US;
                6:       b = model_cmd;
                default: b = model_log;
            endcase
        if (b == CH_STX || b == CH_ETX)
            b = CH_SPC;
        return b;
    endfunction

    // Offers one byte after a random gap and waits for the handshake. When
    // typed_exp is set, the single status item st is expected instead of
    // what the bench model works out; the model still tracks the byte.
    task automatic send_byte(input logic [7:0] b,
                             input logic       typed_exp = 1'b0,
                             input logic [2:0] st = ST_NONE);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        items_sent++;
        predict_rx_byte(b);
        if (typed_exp)
            pending_results.push_back(make_result(KIND_STATUS, 8'h00, st, 1'b1));
        else
            foreach (step_out[i])
                pending_results.push_back(step_out[i]);
    endtask

    // Leaves a frame open; STX closes an open one, so a second may be needed.
    task automatic start_frame();
        send_byte(CH_STX);
        if (!model_open)
            send_byte(CH_STX);
    endtask

    // Mostly well-formed frames with random content, plus enquiries, noise,
    // frames cut off by a restart, and stray ETX bytes.
    task automatic run_traffic(input int n_items);
        int target;
        int len;
        int pick;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                start_frame();
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(0, 6);
                if (pick < 12)
                    send_byte(CH_ENQ);
                repeat (len) send_byte(pick_payload());
                send_byte(CH_ETX);
                if (pick < 12)
                begin
                    // An answered enquiry leaves the frame open; repeat the
                    // question sometimes, then restart to drop it.
                    if ($urandom_range(0, 1) != 0)
                        send_byte(CH_ETX);
                    send_byte(CH_STX);
                end
            end
            else if (pick < 85)
                send_byte(8'($urandom_range(0, 255)));
            else if (pick < 93)
            begin
                start_frame();
                repeat ($urandom_range(1, 4)) send_byte(pick_payload());
                if ($urandom_range(0, 1) != 0)
                    send_byte(CH_STX);
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
                send_byte(CH_ETX);
        end
    endtask

    // Stops offering and waits until every owed result has come out.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_COMMAND)
            model_cmd = val;
        else
            model_log = val;
    endtask

    // Output side: random stalls between items, one long hold-off once the
    // run is under way, and a field-by-field check of every accepted item.
    initial
    begin : result_sink
        int      stall;
        int      hold;
        result_t want;
        stall    = 0;
        hold     = 0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold = HOLD_CYCLES;
                stall = idle_on ? $urandom_range(0, 3) : 0;
                if (pending_results.size() == 0)
                begin
                    $error("result item with none expected: kind %0d data 0x%02h",
                           m_tuser, m_tdata[7:0]);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tuser !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[7:0] !== want.data)
                    begin
                        $error("data: expected 0x%02h, got 0x%02h", want.data,
                               m_tdata[7:0]);
                        error_count++;
                    end
                    if (m_tdata[10:8] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status,
                               m_tdata[10:8]);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_COMMAND;
        cfg_data   = 8'h00;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        model_fill = 0;
        model_open = 1'b0;
        model_cmd  = 8'h01;
        model_log  = 8'h04;
        items_sent = 0;
        idle_on    = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(dir_rows[ROW_W'(i)].rx, dir_rows[ROW_W'(i)].typed_exp,
                      dir_rows[ROW_W'(i)].st);
        run_traffic(40);
        settle();

        // Zero becomes a storable byte and 0xFF too; no idling on either
        // side for this stretch.
        write_reg(CFG_COMMAND, 8'h00);
        write_reg(CFG_LOG, 8'hFF);
        idle_on = 1'b0;

        // Fill the buffer inside a fresh frame, overflow it, then deliver
        // the full 64-byte frame.
        while (!(model_open && model_fill == 0))
            send_byte(CH_STX);
        send_byte(8'h41);
        while (model_fill < BUFFER_DEPTH)
            send_byte(pick_payload());
        repeat (3) send_byte(pick_payload(), 1'b1, ST_REJECT);
        send_byte(CH_ETX);
        run_traffic(30);
        settle();

        write_reg(CFG_COMMAND, 8'hFF);
        write_reg(CFG_LOG, 8'h00);
        idle_on = 1'b1;
        run_traffic(40);
        settle();

        write_reg(CFG_LOG, 8'($urandom_range(0, 255)));
        write_reg(CFG_COMMAND, 8'($urandom_range(0, 255)));
        run_traffic(40);
        settle();

        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[stx_etx_frame_receiver.f]
+incdir+hdl
hdl/stxr_pkg.sv
hdl/stxr_buf.sv
hdl/stxr_ctrl.sv
hdl/stx_etx_frame_receiver.sv
dv/tb.sv
